// ===== design/lzw_variable_width_decoder_defines.svh =====
// Assertion macros for the LZW decoder.
// Used by the control module; expects clk and rst_n in scope.
`ifndef LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH

// same-cycle implication
`define LZWD_ASSERT_IMP(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define LZWD_ASSERT_NXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== design/lzwd_pkg.sv =====
// Shared types and constants for the LZW decoder.
// No dependencies.
package lzwd_pkg;

    localparam int ROOT_COUNT = 256;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_PULL    = 2'd1,
        REQ_RESTART = 2'd2
    } req_e_t;

    typedef enum logic [1:0] {
        STS_ACCEPTED = 2'd0,
        STS_REFUSED  = 2'd1,
        STS_BYTE     = 2'd2,
        STS_NONE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LEAF,
        ST_POP
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        status_t    status;
        logic       done;
        logic       err;
    } res_t;

endpackage

// ===== design/lzwd_ctrl.sv =====
// Decoder sequencer: bit buffer, code decode, dictionary and output stack memories.
// Depends on lzwd_pkg and the defines header.
`include "lzw_variable_width_decoder_defines.svh"
module lzwd_ctrl
    import lzwd_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12,
    parameter int STACK_DEPTH   = 4096
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    output logic idle,
    output res_t res
);

    localparam int IDX_W       = MAX_CODE_BITS;
    localparam int INDEX_COUNT = 1 << IDX_W;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = SP_W + 1;
    localparam int CW_W        = 5;
    localparam int DW          = IDX_W + 8;
    localparam logic [IDX_W-1:0] ROOT     = IDX_W'(ROOT_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(INDEX_COUNT - 2);
    localparam logic [IDX_W-1:0] WL_INIT  = IDX_W'(511);
    localparam logic [CW_W-1:0]  CW_INIT  = CW_W'(9);
    localparam logic [CW_W-1:0]  CW_MAX   = CW_W'(MAX_CODE_BITS);
    localparam logic [CNT_W-1:0] SC_FULL  = CNT_W'(STACK_DEPTH);

    // memories
    logic [DW-1:0]    dict_mem [INDEX_COUNT];
    logic [7:0]       stack_mem [STACK_DEPTH];
    logic [DW-1:0]    dict_rdata_reg;
    logic [7:0]       stack_rdata_reg;
    logic             dict_we, st_we;
    logic [IDX_W-1:0] dict_waddr;
    logic [DW-1:0]    dict_wdata;
    logic [SP_W-1:0]  st_waddr;
    logic [7:0]       st_wdata;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] sc_reg, sc_next;
    logic [23:0]      buf_reg, buf_next;
    logic [4:0]       bc_reg, bc_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [7:0]       first_reg, first_next;
    logic [IDX_W-1:0] nidx_reg, nidx_next;
    logic [CW_W-1:0]  cw_reg, cw_next;
    logic [IDX_W-1:0] wl_reg, wl_next;
    logic [15:0]      bl_reg, bl_next;
    logic [1:0]       hp_reg, hp_next;
    logic             fresh_reg, fresh_next;
    logic             err_reg, err_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] code_reg, code_next;

    logic             pull_ok, dec_go, dec_bad;
    logic [4:0]       shamt;
    logic [23:0]      code_full;
    logic [IDX_W-1:0] code, cur;
    logic [IDX_W-1:0] rd_prefix;
    logic [7:0]       rd_byte;
    logic [IDX_W-1:0] nidx_inc;

    assign pull_ok   = (hp_reg == 2'd2) && (bl_reg != 16'd0) && !err_reg;
    assign shamt     = bc_reg - 5'(cw_reg);
    assign code_full = (buf_reg >> shamt) & ((24'd1 << cw_reg) - 24'd1);
    assign code      = code_full[IDX_W-1:0];
    assign dec_go    = req.valid && (req.kind == REQ_PULL) && pull_ok && (sc_reg == '0)
                       && (bc_reg >= 5'(cw_reg));
    assign dec_bad   = fresh_reg ? (code >= ROOT) : (code > nidx_reg);
    assign cur       = (code == nidx_reg) ? prev_reg : code;
    assign rd_prefix = dict_rdata_reg[IDX_W-1:0];
    assign rd_byte   = dict_rdata_reg[DW-1:IDX_W];
    assign nidx_inc  = nidx_reg + 1'b1;
    assign idle      = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && req.kind == REQ_PULL && pull_ok && sc_reg != '0)
                    state_next = ST_POP;
                else if (dec_go && !dec_bad && !fresh_reg)
                    state_next = (cur >= ROOT) ? ST_WALK : ST_LEAF;
            end
            ST_WALK: state_next = (rd_prefix >= ROOT) ? ST_WALK : ST_LEAF;
            ST_LEAF: state_next = (sc_reg < SC_FULL) ? ST_IDLE : ST_POP;
            ST_POP:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb
    begin
        sc_next    = sc_reg;
        buf_next   = buf_reg;
        bc_next    = bc_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        nidx_next  = nidx_reg;
        cw_next    = cw_reg;
        wl_next    = wl_reg;
        bl_next    = bl_reg;
        hp_next    = hp_reg;
        fresh_next = fresh_reg;
        err_next   = err_reg;
        cur_next   = cur_reg;
        code_next  = code_reg;
        dict_we    = 1'b0;
        dict_waddr = nidx_reg;
        dict_wdata = '0;
        st_we      = 1'b0;
        st_waddr   = sc_reg[SP_W-1:0];
        st_wdata   = '0;
        res.valid  = 1'b0;
        res.data   = 8'd0;
        res.status = STS_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res.valid = 1'b1;
                    case (req.kind)
                        REQ_PUSH:
                        begin
                            res.status = STS_ACCEPTED;
                            if (hp_reg == 2'd0)
                            begin
                                bl_next = {req.data, 8'd0};
                                hp_next = 2'd1;
                            end
                            else if (hp_reg == 2'd1)
                            begin
                                bl_next = {bl_reg[15:8], req.data};
                                hp_next = 2'd2;
                            end
                            else if (bc_reg <= 5'd16)
                            begin
                                buf_next = {buf_reg[15:0], req.data};
                                bc_next  = bc_reg + 5'd8;
                            end
                            else
                                res.status = STS_REFUSED;
                        end
                        REQ_PULL:
                        begin
                            if (pull_ok && sc_reg != '0)
                            begin
                                res.valid = 1'b0;
                                sc_next   = sc_reg - 1'b1;
                                bl_next   = bl_reg - 16'd1;
                            end
                            else if (dec_go)
                            begin
                                bc_next = shamt;
                                if (dec_bad)
                                    err_next = 1'b1;
                                else if (fresh_reg)
                                begin
                                    // single root code: pushed and popped at once
                                    prev_next  = code;
                                    first_next = code[7:0];
                                    fresh_next = 1'b0;
                                    bl_next    = bl_reg - 16'd1;
                                    res.data   = code[7:0];
                                    res.status = STS_BYTE;
                                end
                                else
                                begin
                                    res.valid = 1'b0;
                                    code_next = code;
                                    cur_next  = cur;
                                    if (code == nidx_reg)
                                    begin
                                        st_we    = 1'b1;
                                        st_wdata = first_reg;
                                        sc_next  = sc_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_RESTART:
                        begin
                            res.status = STS_ACCEPTED;
                            sc_next    = '0;
                            buf_next   = '0;
                            bc_next    = '0;
                            prev_next  = '0;
                            first_next = '0;
                            nidx_next  = ROOT;
                            cw_next    = CW_INIT;
                            wl_next    = WL_INIT;
                            bl_next    = '0;
                            hp_next    = '0;
                            fresh_next = 1'b1;
                            err_next   = 1'b0;
                        end
                        default: res.status = STS_NONE;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (sc_reg < SC_FULL)
                begin
                    st_we    = 1'b1;
                    st_wdata = rd_byte;
                    sc_next  = sc_reg + 1'b1;
                end
                cur_next = rd_prefix;
            end
            ST_LEAF:
            begin
                bl_next = bl_reg - 16'd1;
                if (sc_reg < SC_FULL)
                begin
                    // leaf byte goes straight out instead of through the stack
                    res.valid  = 1'b1;
                    res.data   = cur_reg[7:0];
                    res.status = STS_BYTE;
                end
                else
                    sc_next = sc_reg - 1'b1;
                if (nidx_reg == IDX_LAST)
                begin
                    nidx_next  = ROOT;
                    cw_next    = CW_INIT;
                    wl_next    = WL_INIT;
                    fresh_next = 1'b1;
                end
                else
                begin
                    dict_we    = 1'b1;
                    dict_wdata = {cur_reg[7:0], prev_reg};
                    nidx_next  = nidx_inc;
                    if (nidx_inc == wl_reg && cw_reg < CW_MAX)
                    begin
                        cw_next = cw_reg + 1'b1;
                        wl_next = {wl_reg[IDX_W-2:0], 1'b1};
                    end
                end
                prev_next  = code_reg;
                first_next = cur_reg[7:0];
            end
            ST_POP:
            begin
                res.valid  = 1'b1;
                res.data   = stack_rdata_reg;
                res.status = STS_BYTE;
            end
            default: ;
        endcase
        res.done = (hp_next == 2'd2) && (bl_next == 16'd0);
        res.err  = err_next;
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
            dict_mem[dict_waddr] <= dict_wdata;
        dict_rdata_reg <= dict_mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stack_mem[st_waddr] <= st_wdata;
        stack_rdata_reg <= stack_mem[sc_next[SP_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sc_reg    <= '0;
            buf_reg   <= '0;
            bc_reg    <= '0;
            prev_reg  <= '0;
            first_reg <= '0;
            nidx_reg  <= ROOT;
            cw_reg    <= CW_INIT;
            wl_reg    <= WL_INIT;
            bl_reg    <= '0;
            hp_reg    <= '0;
            fresh_reg <= 1'b1;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            buf_reg   <= buf_next;
            bc_reg    <= bc_next;
            prev_reg  <= prev_next;
            first_reg <= first_next;
            nidx_reg  <= nidx_next;
            cw_reg    <= cw_next;
            wl_reg    <= wl_next;
            bl_reg    <= bl_next;
            hp_reg    <= hp_next;
            fresh_reg <= fresh_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        code_reg <= code_next;
    end

    `LZWD_ASSERT_IMP(a_walk_nonroot, state_reg == ST_WALK, cur_reg >= ROOT, "walk on root code")
    `LZWD_ASSERT_IMP(a_stack_bound, 1'b1, sc_reg <= SC_FULL, "stack count overflow")
    `LZWD_ASSERT_NXT(a_restart, state_reg == ST_IDLE && req.valid && req.kind == REQ_RESTART, state_reg == ST_IDLE && nidx_reg == ROOT && !err_reg, "restart did not clear state")

endmodule

// ===== design/lzw_variable_width_decoder.sv =====
// LZW decoder top level: stream handshakes and output register.
// Depends on lzwd_pkg and lzwd_ctrl.
//
// Usage: each input item is a request: tuser 0 pushes the compressed byte in tdata,
// 1 pulls one decompressed byte, 2 restarts a new stream. Every request gives
// exactly one output item carrying a status (tuser), the byte, and the done and
// error flags. The first two pushes of a stream hold the big-endian byte count.
// Per item: push, restart, unknown requests and pulls answered at once
// (no byte ready, an invalid code, or the single-byte first code of a stream)
// are answered from the idle state; a pull served from the output stack needs one
// stack read; a pull that decodes any later code takes one walk step per non-root
// entry in its prefix chain, at one synchronous dictionary read per cycle.
// The answer is registered and shows on the master side the cycle after.
// Reset and restart clear all control state; dictionary and stack contents need
// no clearing, as stale entries are never read. If the receiver stalls, the
// output register holds its item and no new request is taken until it drains.
module lzw_variable_width_decoder
    import lzwd_pkg::*;
#(
    parameter int MAX_CODE_BITS = 12,
    parameter int STACK_DEPTH   = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], stream_done, stream_error, zeros
    output logic [1:0]  m_tuser    // status
);

    req_t       req;
    res_t       res;
    logic       idle;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [9:0] m_data_reg;
    logic [1:0] m_user_reg;

    assign s_tready  = idle && (!m_tvalid_reg || m_tready);
    assign req.valid = s_tvalid && s_tready;
    assign req.kind  = s_tuser;
    assign req.data  = s_tdata;

    lzwd_ctrl #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .idle  (idle),
        .res   (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
            m_tvalid_next = 1'b0;
        if (res.valid)
            m_tvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            m_data_reg <= {res.err, res.done, res.data};
            m_user_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_data_reg};
    assign m_tuser  = m_user_reg;

endmodule
